>>> rtl/polyphase_fir_decimator_by_two_assert.svh
// assertion macros for the polyphase decimator
`ifndef POLYPHASE_FIR_DECIMATOR_BY_TWO_ASSERT_SVH
`define POLYPHASE_FIR_DECIMATOR_BY_TWO_ASSERT_SVH

// checked on the rising clock edge, quiet while reset is held
`define PFD2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define PFD2_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/pfd2_pkg.sv
// shared constants, widths and coefficient rom of the polyphase decimator
package pfd2_pkg;

  localparam int TAPS_PER_PHASE = 32;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_WIDTH     = 18;
  localparam int ROM_TAPS       = 32;

  // derived widths
  localparam int IDX_W  = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;
  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(2 * TAPS_PER_PHASE) + 1;
  localparam int FRAC   = COEF_WIDTH - 1;

  // phase zero coefficients, q1.17
  localparam int COEF_ROM [ROM_TAPS] = '{
    -16, 24, 11, -95, 248, -463, 699, -874,
    870, -546, -240, 1611, -3686, 6688, -11480, 24387,
    52893, -4755, -869, 2706, -3122, 2812, -2153, 1403,
    -734, 238, 61, -190, 202, -154, 90, -52
  };

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  // phase one reads the table back to front, taps past the table are zero
  function automatic logic signed [COEF_WIDTH-1:0] coef_at(logic phase,
                                                           logic [IDX_W-1:0] idx);
    int k;
    k = phase ? (TAPS_PER_PHASE - 1 - int'(idx)) : int'(idx);
    if (k >= ROM_TAPS || k < 0) begin
      return '0;
    end
    return COEF_WIDTH'(COEF_ROM[k]);
  endfunction

endpackage

>>> rtl/pfd2_in_if.sv
// input channel: one beat carries a pair of samples
interface pfd2_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] sample_first;
  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] sample_second;

  modport source (output valid, output sample_first, output sample_second, input ready);
  modport sink   (input valid, input sample_first, input sample_second, output ready);
endinterface

>>> rtl/pfd2_out_if.sv
// output channel: one beat carries one filtered sample
interface pfd2_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] filtered_sample;

  modport source (output valid, output filtered_sample, input ready);
  modport sink   (input valid, input filtered_sample, output ready);
endinterface

>>> rtl/polyphase_fir_decimator_by_two.sv
// top level of the two-phase polyphase fir decimator
// an accepted input beat passes the run, drain and hand-over states before the output beat is valid
// one shared multiply-accumulate serves every tap, so no new pair is taken until the result is handed over
//   (2 x TAPS_PER_PHASE taps, then product drain and output load, which waits while an output beat is pending)
// reset: asynchronous, clears both delay lines, the sequencer and the output valid
module polyphase_fir_decimator_by_two (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfd2_in_if.sink    in_i,
  pfd2_out_if.source out_o
);

  localparam logic [pfd2_pkg::IDX_W-1:0] LAST_IDX =
    pfd2_pkg::IDX_W'(pfd2_pkg::TAPS_PER_PHASE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e                                   state_q;
  logic                                     phase_q;
  logic [pfd2_pkg::IDX_W-1:0]               idx_q;
  logic                                     out_valid_q;
  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] out_data_q;

  logic                                     accept;
  logic                                     last_tap;
  pfd2_pkg::mac_ctrl_t                      mac_ctrl;
  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] tap_sample;
  logic signed [pfd2_pkg::COEF_WIDTH-1:0]   tap_coef;
  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] mac_result;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign last_tap   = phase_q && (idx_q == LAST_IDX);

  assign mac_ctrl.clear = accept;
  assign mac_ctrl.issue = (state_q == ST_RUN);
  assign tap_coef       = pfd2_pkg::coef_at(phase_q, idx_q);

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_sample = out_data_q;

  pfd2_history u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .first_i    (in_i.sample_first),
    .second_i   (in_i.sample_second),
    .rd_phase_i (phase_q),
    .rd_idx_i   (idx_q),
    .rd_data_o  (tap_sample)
  );

  pfd2_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (tap_sample),
    .coef_i   (tap_coef),
    .result_o (mac_result)
  );

  // sequencer: walk phase zero then phase one, drain, hand over the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_o.valid && out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_RUN;
            phase_q <= 1'b0;
            idx_q   <= '0;
          end
        end
        ST_RUN: begin
          if (last_tap) begin
            state_q <= ST_DRAIN;
          end else if (idx_q == LAST_IDX) begin
            phase_q <= 1'b1;
            idx_q   <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= mac_result;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `include "polyphase_fir_decimator_by_two_assert.svh"

  // input ready drops once a pair is taken
  `PFD2_ASSERT(a_busy_after_accept, accept |=> !in_i.ready, "input ready after accept")
  // a new output beat only comes out of the hand-over state
  `PFD2_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "stray output")
  // tap index stays inside the delay line while running
  `PFD2_ASSERT(a_idx_range, (state_q == ST_RUN) |-> (idx_q <= LAST_IDX), "tap index out of range")
  // no output beat is pending while reset is held
  `PFD2_ASSERT_ALWAYS(a_reset_clear, !rst_ni |-> !out_o.valid, "output valid during reset")

endmodule

>>> rtl/pfd2_history.sv
// two delay lines, one per phase, with a single indexed read port
module pfd2_history (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     push_i,
  input  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] first_i,
  input  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] second_i,
  input  logic                                     rd_phase_i,
  input  logic [pfd2_pkg::IDX_W-1:0]               rd_idx_i,
  output logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] rd_data_o
);

  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] line0_q [pfd2_pkg::TAPS_PER_PHASE];
  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] line1_q [pfd2_pkg::TAPS_PER_PHASE];

  // shift down by one, newest sample lands at the top index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pfd2_pkg::TAPS_PER_PHASE; i++) begin
        line0_q[i] <= '0;
        line1_q[i] <= '0;
      end
    end else if (push_i) begin
      for (int i = 0; i + 1 < pfd2_pkg::TAPS_PER_PHASE; i++) begin
        line0_q[i] <= line0_q[i+1];
        line1_q[i] <= line1_q[i+1];
      end
      line0_q[pfd2_pkg::TAPS_PER_PHASE-1] <= first_i;
      line1_q[pfd2_pkg::TAPS_PER_PHASE-1] <= second_i;
    end
  end

  // tap select for the shared multiplier
  assign rd_data_o = rd_phase_i ? line1_q[rd_idx_i] : line0_q[rd_idx_i];

endmodule

>>> rtl/pfd2_mac.sv
// shared multiply-accumulate unit with rounding and saturation of the sum
module pfd2_mac (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  pfd2_pkg::mac_ctrl_t                      ctrl_i,
  input  logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [pfd2_pkg::COEF_WIDTH-1:0]   coef_i,
  output logic signed [pfd2_pkg::SAMPLE_WIDTH-1:0] result_o
);

  localparam logic signed [pfd2_pkg::ACC_W-1:0] RND_HALF =
    pfd2_pkg::ACC_W'(64'sd1 <<< (pfd2_pkg::FRAC - 1));
  localparam logic signed [pfd2_pkg::ACC_W-1:0] SAT_HI =
    pfd2_pkg::ACC_W'((64'sd1 <<< (pfd2_pkg::SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [pfd2_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - 1;

  logic signed [pfd2_pkg::PROD_W-1:0] prod_q;
  logic                               prod_vld_q;
  logic signed [pfd2_pkg::ACC_W-1:0]  acc_q;
  logic signed [pfd2_pkg::ACC_W-1:0]  rnd;
  logic signed [pfd2_pkg::ACC_W-1:0]  shf;

  // product register then accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.issue;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + pfd2_pkg::ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= sample_i * coef_i;
    end
  end

  // round half up to the sample grid, then clamp
  always_comb begin
    rnd = acc_q + RND_HALF;
    shf = rnd >>> pfd2_pkg::FRAC;
    if (shf > SAT_HI) begin
      result_o = pfd2_pkg::SAMPLE_WIDTH'(SAT_HI);
    end else if (shf < SAT_LO) begin
      result_o = pfd2_pkg::SAMPLE_WIDTH'(SAT_LO);
    end else begin
      result_o = pfd2_pkg::SAMPLE_WIDTH'(shf);
    end
  end

endmodule
